// ===== rtl/core/esv_pkg.sv =====
// shared types, constants and register indexes for the signature block
// no dependencies
package esv_pkg;

    localparam int W = 16;

    localparam logic [1:0] REG_MODULUS   = 2'd0;
    localparam logic [1:0] REG_GENERATOR = 2'd1;
    localparam logic [1:0] REG_KEY       = 2'd2;

    localparam logic [W-1:0] RST_MODULUS   = 16'd23;
    localparam logic [W-1:0] RST_GENERATOR = 16'd5;
    localparam logic [W-1:0] RST_KEY       = 16'd1;

    typedef struct packed {
        logic [W-1:0] nonce;
        logic [W-1:0] message_hash;
    } in_word_t;

    typedef struct packed {
        logic [W-1:0] public_key;
        logic [W-1:0] sig_first;
        logic [W-1:0] sig_second;
        logic [W-1:0] check_left;
        logic [W-1:0] check_right;
        logic         verified;
        logic         nonce_invalid;
    } out_word_t;

    typedef struct packed {
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic [W-1:0] m;
    } mm_req_t;

endpackage

// ===== rtl/core/esv_modmul.sv =====
// bit-serial modular multiplier, one bit of a per cycle, msb first
// depends on esv_pkg; requires a, b < m and m >= 1
module esv_modmul
    import esv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  mm_req_t      req,
    output logic         done,
    output logic [W-1:0] prod
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  m_reg, m_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [W:0] dbl, dbl_r, add1, add_r;

    always_comb
    begin
        dbl   = {acc_reg, 1'b0};
        dbl_r = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        add1  = dbl_r + (a_reg[W-1] ? {1'b0, b_reg} : '0);
        add_r = (add1 >= {1'b0, m_reg}) ? add1 - {1'b0, m_reg} : add1;
    end

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = req.a;
            b_next    = req.b;
            m_next    = req.m;
            acc_next  = '0;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = add_r[W-1:0];
            a_next   = {a_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

`ifndef ASSERT_OFF
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("done while busy");
    a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (acc_reg < m_reg))
        else $error("product not reduced");
    a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held two cycles");
`endif

endmodule

// ===== rtl/core/elgamal_sign_verify.sv =====
// top level: elgamal signature generation and verification sequencer
// depends on esv_pkg and esv_modmul
//
// channel  direction  handshake           payload
// in       input      in_valid/in_ready   in_word_t (nonce, message_hash)
// out      output     out_valid/out_ready out_word_t
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// one word at a time; 5 exponentiations of up to 32 modmuls each, plus up to about 24
// euclid steps; a word finishes sooner for short exponents or a modulus below 2.
// reset loads q=23, alpha=5, x=1; a finished word waits in the output register
// until taken and the next word is accepted only after that.
module elgamal_sign_verify
    import esv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  in_word_t     in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output out_word_t    out_data,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [W-1:0] cfg_data
);

    localparam int CW = $clog2(W + 1);
    localparam int SW = 5;

    // sequencer states
    localparam logic [SW-1:0] S_IDLE   = 5'd0;
    localparam logic [SW-1:0] S_EXP    = 5'd1;  // start of an exponentiation
    localparam logic [SW-1:0] S_EMUL   = 5'd2;  // acc*base
    localparam logic [SW-1:0] S_ESQ    = 5'd3;  // base*base
    localparam logic [SW-1:0] S_EWAIT  = 5'd4;
    localparam logic [SW-1:0] S_EDONE  = 5'd5;
    localparam logic [SW-1:0] S_GDIV   = 5'd6;  // euclid division step
    localparam logic [SW-1:0] S_GUPD   = 5'd7;  // unused; the q*t1 product is started in S_GDIVW
    localparam logic [SW-1:0] S_GUPW   = 5'd8;
    localparam logic [SW-1:0] S_SXS    = 5'd9;  // x*s1 mod n
    localparam logic [SW-1:0] S_SXSW   = 5'd10;
    localparam logic [SW-1:0] S_SKD    = 5'd11; // unused; kinv*d mod n is started from S_SXSW
    localparam logic [SW-1:0] S_SKDW   = 5'd12;
    localparam logic [SW-1:0] S_V2     = 5'd13; // product of the two powers
    localparam logic [SW-1:0] S_V2W    = 5'd14;
    localparam logic [SW-1:0] S_OUT    = 5'd15;
    localparam logic [SW-1:0] S_REDW   = 5'd17;
    localparam logic [SW-1:0] S_GDIVW  = 5'd18;

    // exponent jobs
    localparam logic [2:0] J_Y  = 3'd0;
    localparam logic [2:0] J_S1 = 3'd1;
    localparam logic [2:0] J_V1 = 3'd2;
    localparam logic [2:0] J_P1 = 3'd3;
    localparam logic [2:0] J_P2 = 3'd4;

    // reduction jobs for the divider in plain mod use
    localparam logic [1:0] R_BASE = 2'd0;
    localparam logic [1:0] R_KN   = 2'd1;
    localparam logic [1:0] R_XN   = 2'd2;
    localparam logic [1:0] R_HN   = 2'd3;

    logic [W-1:0] q_reg, alpha_reg, x_reg;
    logic [SW-1:0] st_reg, st_next;
    logic [2:0]   job_reg, job_next;
    logic [1:0]   rj_reg, rj_next;
    logic         ret_gcd_reg, ret_gcd_next;

    logic [W-1:0] k_reg, k_next, h_reg, h_next;
    logic [W-1:0] y_reg, y_next, s1_reg, s1_next, s2_reg, s2_next;
    logic [W-1:0] v1_reg, v1_next, p1_reg, p1_next;
    logic         bad_reg, bad_next;

    // exponentiation
    logic [W-1:0] base_reg, base_next, pacc_reg, pacc_next, e_reg, e_next;
    // euclid
    logic [W-1:0] r0_reg, r0_next, r1_reg, r1_next;
    logic [W-1:0] t0_reg, t0_next, t1_reg, t1_next;  // kept mod n
    logic [W-1:0] kn_reg, kn_next, xn_reg, xn_next, hn_reg, hn_next;

    // restoring divider
    logic [W-1:0] dn_reg, dn_next, dd_reg, dd_next, dr_reg, dr_next;
    logic [CW-1:0] dc_reg, dc_next;
    logic         dbusy_reg, dbusy_next;
    logic         dstart;
    logic [W-1:0] dstart_n, dstart_d;
    logic [W:0]   dtrial;

    logic [W-1:0] nmod;
    logic         mm_start;
    mm_req_t      mm_req;
    logic         mm_done;
    logic [W-1:0] mm_prod;
    out_word_t    ow_reg, ow_next;
    logic         ov_reg, ov_next;
    logic [W-1:0] one_q;
    logic [W:0]   dsum;

    assign nmod  = q_reg - 1'b1;
    assign one_q = (q_reg <= W'(1)) ? '0 : W'(1);

    esv_modmul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .req   (mm_req),
        .done  (mm_done),
        .prod  (mm_prod)
    );

    // restoring divider: quotient in dn_reg, remainder in dr_reg
    assign dtrial = {dr_reg, dn_reg[W-1]};
    always_comb
    begin
        dn_next    = dn_reg;
        dd_next    = dd_reg;
        dr_next    = dr_reg;
        dc_next    = dc_reg;
        dbusy_next = dbusy_reg;
        if (dstart)
        begin
            dn_next    = dstart_n;
            dd_next    = dstart_d;
            dr_next    = '0;
            dc_next    = CW'(W);
            dbusy_next = 1'b1;
        end
        else if (dbusy_reg)
        begin
            if (dtrial >= {1'b0, dd_reg})
            begin
                dr_next = W'(dtrial - {1'b0, dd_reg});
                dn_next = {dn_reg[W-2:0], 1'b1};
            end
            else
            begin
                dr_next = dtrial[W-1:0];
                dn_next = {dn_reg[W-2:0], 1'b0};
            end
            dc_next = dc_reg - 1'b1;
            if (dc_reg == CW'(1))
                dbusy_next = 1'b0;
        end
    end

    // exponent source per job
    function automatic logic [W-1:0] exp_of(input logic [2:0] j, input logic [W-1:0] x,
        input logic [W-1:0] k, input logic [W-1:0] h, input logic [W-1:0] s1,
        input logic [W-1:0] s2);
        logic [W-1:0] r;
        begin
            r = s2;
            if (j == J_Y)  r = x;
            if (j == J_S1) r = k;
            if (j == J_V1) r = h;
            if (j == J_P1) r = s1;
            return r;
        end
    endfunction

    function automatic logic [W-1:0] base_of(input logic [2:0] j, input logic [W-1:0] a,
        input logic [W-1:0] y, input logic [W-1:0] s1);
        logic [W-1:0] r;
        begin
            r = a;
            if (j == J_P1) r = y;
            if (j == J_P2) r = s1;
            return r;
        end
    endfunction

    always_comb
    begin
        st_next      = st_reg;
        job_next     = job_reg;
        rj_next      = rj_reg;
        ret_gcd_next = ret_gcd_reg;
        k_next = k_reg; h_next = h_reg;
        y_next = y_reg; s1_next = s1_reg; s2_next = s2_reg;
        v1_next = v1_reg; p1_next = p1_reg; bad_next = bad_reg;
        base_next = base_reg; pacc_next = pacc_reg; e_next = e_reg;
        r0_next = r0_reg; r1_next = r1_reg; t0_next = t0_reg; t1_next = t1_reg;
        kn_next = kn_reg; xn_next = xn_reg; hn_next = hn_reg;
        ow_next = ow_reg; ov_next = ov_reg;
        dstart = 1'b0; dstart_n = '0; dstart_d = W'(1);
        mm_start = 1'b0;
        mm_req = '{a: '0, b: '0, m: W'(1)};
        dsum = '0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;

        unique case (st_reg)
            S_IDLE:
            begin
                if (in_valid && !ov_reg)
                begin
                    k_next   = in_data.nonce;
                    h_next   = in_data.message_hash;
                    s2_next  = '0;
                    job_next = J_Y;
                    st_next  = S_EXP;
                end
            end
            S_EXP:
            begin
                // reduce base mod q first
                e_next    = exp_of(job_reg, x_reg, k_reg, h_reg, s1_reg, s2_reg);
                pacc_next = one_q;
                if (q_reg <= W'(1))
                begin
                    base_next = '0;
                    st_next   = S_EDONE;
                end
                else
                begin
                    dstart   = 1'b1;
                    dstart_n = base_of(job_reg, alpha_reg, y_reg, s1_reg);
                    dstart_d = q_reg;
                    rj_next  = R_BASE;
                    st_next  = S_REDW;
                end
            end
            S_REDW:
            begin
                if (!dbusy_reg && !dstart)
                begin
                    unique case (rj_reg)
                        R_BASE:
                        begin
                            base_next = dr_reg;
                            st_next   = S_EMUL;
                        end
                        R_KN:
                        begin
                            kn_next  = dr_reg;
                            dstart   = 1'b1;
                            dstart_n = x_reg;
                            dstart_d = nmod;
                            rj_next  = R_XN;
                        end
                        R_XN:
                        begin
                            xn_next  = dr_reg;
                            dstart   = 1'b1;
                            dstart_n = h_reg;
                            dstart_d = nmod;
                            rj_next  = R_HN;
                        end
                        R_HN:
                        begin
                            hn_next = dr_reg;
                            r0_next = nmod;
                            r1_next = kn_reg;
                            t0_next = '0;
                            t1_next = W'(1);
                            if (nmod == W'(1))
                            begin
                                t0_next = '0;
                                st_next = S_SXS;
                            end
                            else
                                st_next = S_GDIV;
                        end
                        default: st_next = S_IDLE;
                    endcase
                end
            end
            S_EMUL:
            begin
                if (e_reg == '0)
                    st_next = S_EDONE;
                else if (e_reg[0])
                begin
                    mm_start = 1'b1;
                    mm_req   = '{a: pacc_reg, b: base_reg, m: q_reg};
                    ret_gcd_next = 1'b0;
                    st_next  = S_EWAIT;
                end
                else
                    st_next = S_ESQ;
            end
            S_EWAIT:
            begin
                if (mm_done)
                begin
                    if (!ret_gcd_reg)
                    begin
                        pacc_next = mm_prod;
                        st_next   = S_ESQ;
                    end
                    else
                    begin
                        base_next = mm_prod;
                        e_next    = {1'b0, e_reg[W-1:1]};
                        st_next   = S_EMUL;
                    end
                end
            end
            S_ESQ:
            begin
                mm_start = 1'b1;
                mm_req   = '{a: base_reg, b: base_reg, m: q_reg};
                ret_gcd_next = 1'b1;
                st_next  = S_EWAIT;
            end
            S_EDONE:
            begin
                unique case (job_reg)
                    J_Y:
                    begin
                        y_next   = pacc_reg;
                        job_next = J_S1;
                        st_next  = S_EXP;
                    end
                    J_S1:
                    begin
                        s1_next = pacc_reg;
                        if (q_reg < W'(2))
                        begin
                            bad_next = 1'b1;
                            job_next = J_V1;
                            st_next  = S_EXP;
                        end
                        else
                        begin
                            bad_next = 1'b0;
                            dstart   = 1'b1;
                            dstart_n = k_reg;
                            dstart_d = nmod;
                            rj_next  = R_KN;
                            st_next  = S_REDW;
                        end
                    end
                    J_V1:
                    begin
                        v1_next  = pacc_reg;
                        job_next = J_P1;
                        st_next  = S_EXP;
                    end
                    J_P1:
                    begin
                        p1_next  = pacc_reg;
                        job_next = J_P2;
                        st_next  = S_EXP;
                    end
                    default:
                    begin
                        if (q_reg <= W'(1))
                        begin
                            ow_next = '{public_key: y_reg, sig_first: s1_reg,
                                sig_second: s2_reg, check_left: v1_reg,
                                check_right: '0, verified: (v1_reg == '0),
                                nonce_invalid: bad_reg};
                            st_next = S_OUT;
                        end
                        else
                            st_next = S_V2;
                    end
                endcase
            end
            S_GDIV:
            begin
                if (r1_reg == '0)
                begin
                    if (r0_reg != W'(1))
                    begin
                        bad_next = 1'b1;
                        job_next = J_V1;
                        st_next  = S_EXP;
                    end
                    else
                        st_next = S_SXS;
                end
                else
                begin
                    dstart   = 1'b1;
                    dstart_n = r0_reg;
                    dstart_d = r1_reg;
                    st_next  = S_GDIVW;
                end
            end
            S_GDIVW:
            begin
                if (!dbusy_reg && !dstart)
                begin
                    r0_next = r1_reg;
                    r1_next = dr_reg;
                    // quotient at most n since r1 >= 1 and r0 <= n; t1 < n
                    mm_start = 1'b1;
                    mm_req   = '{a: dn_reg < nmod ? dn_reg : dn_reg - nmod,
                                 b: t1_reg, m: nmod};
                    st_next  = S_GUPW;
                end
            end
            S_GUPW:
            begin
                if (mm_done)
                begin
                    dsum    = {1'b0, t0_reg} + {1'b0, nmod} - {1'b0, mm_prod};
                    t0_next = t1_reg;
                    t1_next = (dsum >= {1'b0, nmod}) ? W'(dsum - {1'b0, nmod})
                                                      : dsum[W-1:0];
                    st_next = S_GDIV;
                end
            end
            S_SXS:
            begin
                // t0 holds k^-1 mod n; s1 < q so s1 mod n is s1 or zero
                mm_start = 1'b1;
                mm_req   = '{a: xn_reg, b: (s1_reg >= nmod) ? s1_reg - nmod : s1_reg,
                             m: nmod};
                st_next  = S_SXSW;
            end
            S_SXSW:
            begin
                if (mm_done)
                begin
                    dsum     = {1'b0, hn_reg} + {1'b0, nmod} - {1'b0, mm_prod};
                    mm_start = 1'b1;
                    mm_req   = '{a: t0_reg,
                                 b: (dsum >= {1'b0, nmod}) ? W'(dsum - {1'b0, nmod})
                                                            : dsum[W-1:0],
                                 m: nmod};
                    st_next  = S_SKDW;
                end
            end
            S_SKD:
            begin
                st_next = S_SKDW;
            end
            S_SKDW:
            begin
                if (mm_done)
                begin
                    s2_next  = mm_prod;
                    job_next = J_V1;
                    st_next  = S_EXP;
                end
            end
            S_V2:
            begin
                mm_start = 1'b1;
                mm_req   = '{a: p1_reg, b: pacc_reg, m: q_reg};
                st_next  = S_V2W;
            end
            S_V2W:
            begin
                if (mm_done)
                begin
                    ow_next = '{public_key: y_reg, sig_first: s1_reg,
                        sig_second: s2_reg, check_left: v1_reg,
                        check_right: mm_prod, verified: (v1_reg == mm_prod),
                        nonce_invalid: bad_reg};
                    st_next = S_OUT;
                end
            end
            S_OUT:
            begin
                ov_next = 1'b1;
                st_next = S_IDLE;
            end
            S_GUPD:
            begin
                st_next = S_GDIV;
            end
            default: st_next = S_IDLE;
        endcase
    end

    assign in_ready  = (st_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = ow_reg;
    assign cfg_ready = (st_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= S_IDLE;
            ov_reg      <= 1'b0;
            dbusy_reg   <= 1'b0;
            dc_reg      <= '0;
            job_reg     <= J_Y;
            rj_reg      <= R_BASE;
            ret_gcd_reg <= 1'b0;
            q_reg       <= RST_MODULUS;
            alpha_reg   <= RST_GENERATOR;
            x_reg       <= RST_KEY;
        end
        else
        begin
            st_reg      <= st_next;
            ov_reg      <= ov_next;
            dbusy_reg   <= dbusy_next;
            dc_reg      <= dc_next;
            job_reg     <= job_next;
            rj_reg      <= rj_next;
            ret_gcd_reg <= ret_gcd_next;
            if (cfg_valid && cfg_ready)
            begin
                priority case (cfg_index)
                    REG_MODULUS:   q_reg     <= cfg_data;
                    REG_GENERATOR: alpha_reg <= cfg_data;
                    REG_KEY:       x_reg     <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next; h_reg <= h_next;
        y_reg <= y_next; s1_reg <= s1_next; s2_reg <= s2_next;
        v1_reg <= v1_next; p1_reg <= p1_next; bad_reg <= bad_next;
        base_reg <= base_next; pacc_reg <= pacc_next; e_reg <= e_next;
        r0_reg <= r0_next; r1_reg <= r1_next; t0_reg <= t0_next; t1_reg <= t1_next;
        kn_reg <= kn_next; xn_reg <= xn_next; hn_reg <= hn_next;
        dn_reg <= dn_next; dd_reg <= dd_next; dr_reg <= dr_next;
        ow_reg <= ow_next;
    end

`ifndef ASSERT_OFF
    a_busy_in: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_IDLE) |-> !in_ready)
        else $error("input taken while busy");
    a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (st_reg == S_IDLE))
        else $error("result pending while working");
    a_verify: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (ow_reg.verified == (ow_reg.check_left == ow_reg.check_right)))
        else $error("verified flag wrong");
    a_s2_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && ow_reg.nonce_invalid) |-> (ow_reg.sig_second == '0))
        else $error("s2 nonzero for bad nonce");
`endif

endmodule

// ===== dv/tb_elgamal_sign_verify.sv =====
`timescale 1ns / 100ps
// testbench for elgamal_sign_verify: directed and random signing words over several key sets
// depends on esv_pkg and the elgamal_sign_verify rtl
module tb_elgamal_sign_verify;
    import esv_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_word_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_word_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = REG_MODULUS;
    logic [W-1:0] cfg_data = '0;

    logic [W-1:0] sh_modulus = RST_MODULUS;
    logic [W-1:0] sh_generator = RST_GENERATOR;
    logic [W-1:0] sh_key = RST_KEY;

    out_word_t sig_pending[$];
    int errors = 0;
    int stall_cnt = 0;
    bit calm = 1'b0;

    localparam int WATCHDOG = 60000;

    elgamal_sign_verify dut (.*);

    always #6 clk = ~clk;

    function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                                longint unsigned m);
        longint unsigned acc;
        if (m <= 1) return 0;
        acc = 1;
        b = b % m;
        while (e > 0)
        begin
            if (e[0]) acc = (acc * b) % m;
            b = (b * b) % m;
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic bit inv_mod(longint unsigned a, longint unsigned n,
                                   output longint unsigned res);
        longint r0, r1, t0, t1, qt, tmp;
        res = 0;
        if (n == 1) return 1'b1;
        r0 = n;
        r1 = a % n;
        t0 = 0;
        t1 = 1;
        while (r1 != 0)
        begin
            qt = r0 / r1;
            tmp = r0 - qt * r1;
            r0 = r1;
            r1 = tmp;
            tmp = t0 - qt * t1;
            t0 = t1;
            t1 = tmp;
        end
        if (r0 != 1) return 1'b0;
        if (t0 < 0) t0 = t0 + n;
        res = longint'(t0) % n;
        return 1'b1;
    endfunction

    function automatic out_word_t sign_and_check(logic [W-1:0] k, logic [W-1:0] h);
        longint unsigned q, n, y, s1, s2, v1, v2, kinv, xs, d;
        bit bad;
        out_word_t r;
        q = sh_modulus;
        s2 = 0;
        y = pow_mod(sh_generator, sh_key, q);
        s1 = pow_mod(sh_generator, k, q);
        if (q < 2) bad = 1'b1;
        else
        begin
            n = q - 1;
            bad = !inv_mod(k, n, kinv);
            if (!bad)
            begin
                xs = ((sh_key % n) * (s1 % n)) % n;
                d = (h % n + n - xs) % n;
                s2 = (kinv * d) % n;
            end
        end
        v1 = pow_mod(sh_generator, h, q);
        v2 = (q <= 1) ? 0 : (pow_mod(y, s1, q) * pow_mod(s1, s2, q)) % q;
        r.public_key = y[W-1:0];
        r.sig_first = s1[W-1:0];
        r.sig_second = s2[W-1:0];
        r.check_left = v1[W-1:0];
        r.check_right = v2[W-1:0];
        r.verified = (v1 == v2);
        r.nonce_invalid = bad;
        return r;
    endfunction

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    task automatic send_word(logic [W-1:0] k, logic [W-1:0] h);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{nonce: k, message_hash: h};
        do @(posedge clk); while (!in_ready);
        sig_pending.push_back(sign_and_check(k, h));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sig_pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MODULUS: sh_modulus = val;
            REG_GENERATOR: sh_generator = val;
            default: sh_key = val;
        endcase
        @(posedge clk);
    endtask

    task automatic load_keys(logic [W-1:0] q, logic [W-1:0] g, logic [W-1:0] x);
        drain();
        write_reg(REG_MODULUS, q);
        write_reg(REG_GENERATOR, g);
        write_reg(REG_KEY, x);
    endtask

    task automatic test_reset_keys();
        send_word(16'd3, 16'd7);
        send_word(16'd0, 16'd0);
        send_word(16'd2, 16'hffff);
        send_word(16'hffff, 16'd1);
    endtask

    task automatic test_degenerate_moduli();
        load_keys(16'd0, 16'd5, 16'd3);
        send_word(16'd5, 16'd9);
        load_keys(16'd1, 16'd2, 16'd3);
        send_word(16'd5, 16'd9);
        load_keys(16'd2, 16'd1, 16'd0);
        send_word(16'd4, 16'd9);
        send_word(16'd1, 16'hffff);
    endtask

    task automatic test_field_extremes();
        load_keys(16'd65521, 16'd17, 16'hffff);
        send_word(16'd1, 16'hffff);
        send_word(16'hffff, 16'd0);
        send_word(16'd65519, 16'h8000);
        send_word(16'd6, 16'd1234);
        send_word(16'd0, 16'h5555);
        load_keys(16'd65521, 16'hffff, 16'd0);
        send_word(16'd7, 16'haaaa);
        send_word(16'd2, 16'd3);
        load_keys(16'hffff, 16'd1, 16'd1);
        send_word(16'd13, 16'd77);
    endtask

    task automatic test_random(int phases, int per_phase, bit quiet);
        int unsigned primes[9] = '{3, 5, 7, 23, 257, 4099, 32749, 65519, 65521};
        logic [W-1:0] q, k;
        for (int p = 0; p < phases; p++)
        begin
            q = ($urandom_range(0, 4) == 0) ? W'($urandom_range(3, 65535))
                                            : W'(primes[$urandom_range(0, 8)]);
            load_keys(q, W'($urandom_range(1, 65535)), W'($urandom()));
            calm = quiet && (p % 3 == 0);
            for (int i = 0; i < per_phase; i++)
            begin
                case ($urandom_range(0, 3))
                    0: k = W'($urandom_range(0, 15));
                    1: k = $urandom_range(0, 1) ? 16'hffff : q - 16'd1;
                    default: k = W'($urandom());
                endcase
                send_word(k, W'($urandom()));
                if (p == 1 && i == per_phase / 2) drain();
            end
            calm = 1'b0;
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_keys();
        test_degenerate_moduli();
        test_field_extremes();
        test_random(10, 148, 1'b1);
        drain();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (sig_pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected word %p", out_data);
            end
            else
            begin
                e = sig_pending.pop_front();
                if (out_data.public_key !== e.public_key
                    || out_data.sig_first !== e.sig_first
                    || out_data.sig_second !== e.sig_second
                    || out_data.check_left !== e.check_left
                    || out_data.check_right !== e.check_right
                    || out_data.verified !== e.verified
                    || out_data.nonce_invalid !== e.nonce_invalid)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch q=%0d exp %p got %p", sh_modulus, e, out_data);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            stall_cnt <= 0;
        else if (stall_cnt >= WATCHDOG)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            stall_cnt <= stall_cnt + 1;
    end

endmodule

// ===== filelist.f =====
rtl/core/esv_pkg.sv
rtl/core/esv_modmul.sv
rtl/core/elgamal_sign_verify.sv
dv/tb_elgamal_sign_verify.sv
